// ===== src/proximity_track_table_unit_assert.svh =====
// Assertion macros used by the checker file of the proximity track table.
// No dependencies; each macro expects clk and arst_n in scope.
`ifndef PROXIMITY_TRACK_TABLE_UNIT_ASSERT_SVH
`define PROXIMITY_TRACK_TABLE_UNIT_ASSERT_SVH
// Overlapping implication, checked outside reset.
`define PTTU_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pttu check failed");
// Implication in the following cycle, checked outside reset.
`define PTTU_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pttu check failed");
`endif

// ===== src/pttu_pkg.sv =====
// Package of the proximity track table: sizes, codes, item, result, entry and state types.
// No dependencies.
`timescale 1ns / 1ps
package pttu_pkg;
	localparam int TABLE_DEPTH = 16;
	localparam int ID_MAX = 65000;
	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

	localparam logic [1:0] ST_MATCHED = 2'd0;
	localparam logic [1:0] ST_ADDED   = 2'd1;
	localparam logic [1:0] ST_DROPPED = 2'd2;
	localparam logic [1:0] ST_ENTRY   = 2'd0;
	localparam logic [1:0] ST_EMPTY   = 2'd1;
	localparam logic KIND_DET = 1'b0;
	localparam logic KIND_REP = 1'b1;
	localparam logic MODE_DET = 1'b0;
	localparam logic REG_RADIUS = 1'b0;
	localparam logic REG_LIFETIME = 1'b1;

	typedef struct packed {
		logic mode;
		logic signed [23:0] pos_x;
		logic signed [23:0] pos_y;
		logic [31:0] time_now;
	} item_t;

	typedef struct packed {
		logic kind;
		logic [1:0] status;
		logic [15:0] track_id;
		logic signed [23:0] out_x;
		logic signed [23:0] out_y;
		logic last;
	} result_t;

	typedef struct packed {
		logic [23:0] x;
		logic [23:0] y;
		logic [31:0] stamp;
		logic [15:0] ident;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef enum logic [2:0] {
		S_IDLE, S_DRD, S_DSQ, S_DCMP, S_RRD, S_REV, S_RFIN
	} state_t;
endpackage

// ===== src/proximity_track_table_unit.sv =====
// Top level of the proximity track table: sequencer around one entry RAM.
// Depends on pttu_pkg and pttu_ram.
`timescale 1ns / 1ps
// An item is taken when start is high while busy is low. A detection item
// (mode 0) scans the stored entries oldest first for one closer than the
// match radius; a match refreshes its timestamp, otherwise the point is
// appended with the next id, or dropped when the table is full. It always
// gives one result. A report item (mode 1) walks the table once, compacting
// out entries older than the lifetime, and reports every survivor, the last
// one marked; an empty table gives nothing, a fully expired one gives one
// empty marker.
// Each result is shown for one cycle with result_valid high; the receiver
// cannot stall, so every result is a transfer in the cycle it appears.
// A detection reads, squares and compares each stored entry in turn (S_DRD,
// S_DSQ, S_DCMP) until a match or the end of the table; a report reads and
// evaluates each stored entry in turn (S_RRD, S_REV) and finishes in S_RFIN.
// The entry RAM has a single read port and a registered read. No new item
// is taken while busy is high.
// busy drops in the cycle the last result is shown. Reset empties the table
// (count and next id to zero) and loads radius 200 and lifetime 550; the RAM
// is not cleared. Registers: byte 0 (match_radius), byte 4 (lifetime).
module proximity_track_table_unit
	import pttu_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  item_t item,
	output logic result_valid,
	output result_t result,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [2:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	state_t state_q, state_d;
	item_t item_q;
	logic [15:0] radius_q, lifetime_q;
	logic [31:0] r2_q;
	logic [CNT_W-1:0] count_q, count_d, idx_q, idx_d, keep_q, keep_d;
	logic [15:0] next_id_q, next_id_d;
	logic pend_v_q, pend_v_d;
	entry_t pend_q, pend_d;
	entry_t rd_entry, entry_s2;
	logic [31:0] sqx_s2, sqy_s2;
	logic far_s2;
	logic we;
	logic [IDX_W-1:0] waddr, raddr;
	entry_t wdata;
	logic emit;
	result_t emit_res;
	logic [24:0] dx, dy, adx, ady;
	logic [32:0] d2;
	logic [31:0] age;
	logic take;

	assign pready = 1'b1;
	assign busy = (state_q != S_IDLE);
	assign take = start && !busy;
	assign prdata = (paddr[2] == REG_LIFETIME) ? {16'd0, lifetime_q} : {16'd0, radius_q};

	pttu_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_DEPTH)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr(raddr), .rdata(rd_entry)
	);

	// Distance terms: anything at least 2^16 away on one axis can never match,
	// so only the low 16 bits of each magnitude are squared.
	assign dx = {rd_entry.x[23], rd_entry.x} - {item_q.pos_x[23], item_q.pos_x};
	assign dy = {rd_entry.y[23], rd_entry.y} - {item_q.pos_y[23], item_q.pos_y};
	assign adx = dx[24] ? (~dx + 25'd1) : dx;
	assign ady = dy[24] ? (~dy + 25'd1) : dy;
	assign d2 = {1'b0, sqx_s2} + {1'b0, sqy_s2};
	assign age = item_q.time_now - rd_entry.stamp;

	always_comb begin
		state_d = state_q;
		count_d = count_q;
		idx_d = idx_q;
		keep_d = keep_q;
		next_id_d = next_id_q;
		pend_v_d = pend_v_q;
		pend_d = pend_q;
		we = 1'b0;
		waddr = idx_q[IDX_W-1:0];
		wdata = '{x: item_q.pos_x, y: item_q.pos_y, stamp: item_q.time_now,
			ident: next_id_q};
		raddr = idx_q[IDX_W-1:0];
		emit = 1'b0;
		emit_res = '{kind: KIND_DET, status: ST_MATCHED, track_id: 16'd0,
			out_x: 24'sd0, out_y: 24'sd0, last: 1'b1};
		unique case (state_q)
			S_IDLE: begin
				idx_d = '0;
				keep_d = '0;
				pend_v_d = 1'b0;
				if (take) begin
					if (item.mode == MODE_DET) begin
						state_d = S_DRD;
					end else if (count_q != '0) begin
						state_d = S_RRD;
					end
				end
			end
			S_DRD: begin
				if (idx_q == count_q) begin
					emit = 1'b1;
					state_d = S_IDLE;
					if (count_q == CNT_W'(TABLE_DEPTH)) begin
						emit_res.status = ST_DROPPED;
					end else begin
						we = 1'b1;
						waddr = count_q[IDX_W-1:0];
						count_d = count_q + 1'b1;
						emit_res.status = ST_ADDED;
						emit_res.track_id = next_id_q;
						next_id_d = (next_id_q >= 16'(ID_MAX)) ? 16'd0 : next_id_q + 16'd1;
					end
				end else begin
					state_d = S_DSQ;
				end
			end
			S_DSQ: state_d = S_DCMP;
			S_DCMP: begin
				if (!far_s2 && (d2 < {1'b0, r2_q})) begin
					we = 1'b1;
					wdata = entry_s2;
					wdata.stamp = item_q.time_now;
					emit = 1'b1;
					emit_res.track_id = entry_s2.ident;
					state_d = S_IDLE;
				end else begin
					idx_d = idx_q + 1'b1;
					state_d = S_DRD;
				end
			end
			S_RRD: state_d = S_REV;
			S_REV: begin
				if (age <= {16'd0, lifetime_q}) begin
					we = 1'b1;
					waddr = keep_q[IDX_W-1:0];
					wdata = rd_entry;
					keep_d = keep_q + 1'b1;
					pend_d = rd_entry;
					pend_v_d = 1'b1;
					if (pend_v_q) begin
						emit = 1'b1;
						emit_res = '{kind: KIND_REP, status: ST_ENTRY,
							track_id: pend_q.ident, out_x: pend_q.x,
							out_y: pend_q.y, last: 1'b0};
					end
				end
				idx_d = idx_q + 1'b1;
				state_d = (idx_q + 1'b1 == count_q) ? S_RFIN : S_RRD;
			end
			S_RFIN: begin
				count_d = keep_q;
				emit = 1'b1;
				state_d = S_IDLE;
				if (pend_v_q) begin
					emit_res = '{kind: KIND_REP, status: ST_ENTRY,
						track_id: pend_q.ident, out_x: pend_q.x,
						out_y: pend_q.y, last: 1'b1};
				end else begin
					emit_res.kind = KIND_REP;
					emit_res.status = ST_EMPTY;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			next_id_q <= '0;
			idx_q <= '0;
			keep_q <= '0;
			pend_v_q <= 1'b0;
			radius_q <= 16'd200;
			lifetime_q <= 16'd550;
			result_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			next_id_q <= next_id_d;
			idx_q <= idx_d;
			keep_q <= keep_d;
			pend_v_q <= pend_v_d;
			result_valid <= emit;
			if (psel && penable && pwrite) begin
				if (paddr[2] == REG_RADIUS) begin
					radius_q <= pwdata[15:0];
				end else begin
					lifetime_q <= pwdata[15:0];
				end
			end
		end
	end

	// Payload registers: no reset needed.
	always_ff @(posedge clk) begin
		if (take) begin
			item_q <= item;
			r2_q <= radius_q * radius_q;
		end
		pend_q <= pend_d;
		result <= emit_res;
		entry_s2 <= rd_entry;
		far_s2 <= (adx[24:16] != '0) || (ady[24:16] != '0);
		sqx_s2 <= adx[15:0] * adx[15:0];
		sqy_s2 <= ady[15:0] * ady[15:0];
	end
endmodule

// ===== src/pttu_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module pttu_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic clk,
	input  logic we,
	input  logic [AW-1:0] waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// ===== src/pttu_checker.sv =====
// Port-level checker for the proximity track table, bound to the top level.
// Depends on pttu_pkg and proximity_track_table_unit_assert.svh.
`timescale 1ns / 1ps
`include "proximity_track_table_unit_assert.svh"
module pttu_checker
	import pttu_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input item_t item,
	input logic result_valid,
	input result_t result
);
	// A detection always yields exactly one result.
	`PTTU_ASSERT_NOW(a_det_last, result_valid && result.kind == KIND_DET, result.last)
	`PTTU_ASSERT_NEXT(a_det_single, result_valid && result.kind == KIND_DET, !result_valid)
	// Ids never exceed the wrap point.
	`PTTU_ASSERT_NOW(a_id_range, result_valid, result.track_id <= 16'(ID_MAX))
	// A detection transfer always occupies the block.
	`PTTU_ASSERT_NEXT(a_det_busy, start && !busy && item.mode == MODE_DET, busy)
endmodule

bind proximity_track_table_unit pttu_checker u_pttu_checker (.*);
